// ----- src/imu_fp_pkg.sv -----
// Shared types and constants of the IMU frame parser.
package imu_fp_pkg;

  localparam int FRAME_STORE_DEPTH = 10;
  localparam int POS_WIDTH         = 4;
  localparam int CFG_INDEX_WIDTH   = 3;
  localparam int VALUE_WIDTH       = 32;
  localparam int TOTAL_WIDTH       = 32;
  localparam int LANES             = 4;

  // Byte positions in a frame; 0 means hunting for the header and 10 is the checksum byte.
  localparam logic [POS_WIDTH-1:0] POS_HUNT  = 4'd0;
  localparam logic [POS_WIDTH-1:0] POS_FIRST = 4'd1;
  localparam logic [POS_WIDTH-1:0] POS_CHECK = 4'd10;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HEADER = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACCEL  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RATE   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE  = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT   = 3'd4;

  localparam logic [7:0] RESET_HEADER = 8'd85;
  localparam logic [7:0] RESET_ACCEL  = 8'd81;
  localparam logic [7:0] RESET_RATE   = 8'd82;
  localparam logic [7:0] RESET_ANGLE  = 8'd83;
  localparam logic [7:0] RESET_QUAT   = 8'd89;

  // Frame kinds as reported on the result channel.
  localparam logic [2:0] KIND_BAD   = 3'd0;
  localparam logic [2:0] KIND_ACCEL = 3'd1;
  localparam logic [2:0] KIND_RATE  = 3'd2;
  localparam logic [2:0] KIND_ANGLE = 3'd3;
  localparam logic [2:0] KIND_QUAT  = 3'd4;

  // Q16.16 scale factors: 9.80665 * 16 * 65536 / 32768 is 20084 / 64.
  localparam logic signed [VALUE_WIDTH-1:0] SCALE_ACCEL = 32'sd20084;
  localparam logic signed [VALUE_WIDTH-1:0] SCALE_RATE  = 32'sd4000;
  localparam logic signed [VALUE_WIDTH-1:0] SCALE_ANGLE = 32'sd360;
  localparam logic signed [VALUE_WIDTH-1:0] SCALE_QUAT  = 32'sd2;
  localparam int ACCEL_SHIFT = 6;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] accel_type_code;
    logic [7:0] rate_type_code;
    logic [7:0] angle_type_code;
    logic [7:0] quat_type_code;
  } cfg_t;

  typedef struct packed {
    logic                   done;
    logic                   check_ok;
    logic [7:0]             type_byte;
    logic [LANES-1:0][15:0] words;
  } frame_t;

  typedef struct packed {
    logic [TOTAL_WIDTH-1:0] bad_total;
    logic [TOTAL_WIDTH-1:0] accel_total;
    logic [TOTAL_WIDTH-1:0] rate_total;
    logic [TOTAL_WIDTH-1:0] angle_total;
    logic [TOTAL_WIDTH-1:0] quat_total;
    logic [3:0]             update_mask;
  } stats_t;

  typedef struct packed {
    logic [2:0]                      frame_kind;
    logic [LANES-1:0][VALUE_WIDTH-1:0] values;
    stats_t                          stats;
  } result_t;

endpackage

// ----- src/imu_fp_in_if.sv -----
// Byte channel into the IMU frame parser.
interface imu_fp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       clear_updates;

  modport source (output valid, output rx_byte, output clear_updates, input ready);
  modport sink   (input valid, input rx_byte, input clear_updates, output ready);
endinterface

// ----- src/imu_fp_out_if.sv -----
// Result channel out of the IMU frame parser.
interface imu_fp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         frame_kind;
  logic signed [31:0] value_a;
  logic signed [31:0] value_b;
  logic signed [31:0] value_c;
  logic signed [31:0] value_d;
  logic [31:0]        bad_total;
  logic [31:0]        accel_total;
  logic [31:0]        rate_total;
  logic [31:0]        angle_total;
  logic [31:0]        quat_total;
  logic [3:0]         update_mask;

  modport source (output valid, output frame_kind, output value_a, output value_b,
                  output value_c, output value_d, output bad_total, output accel_total,
                  output rate_total, output angle_total, output quat_total,
                  output update_mask, input ready);
  modport sink   (input valid, input frame_kind, input value_a, input value_b,
                  input value_c, input value_d, input bad_total, input accel_total,
                  input rate_total, input angle_total, input quat_total,
                  input update_mask, output ready);
endinterface

// ----- src/imu_fp_collect.sv -----
// Header hunt, byte collection and running checksum of the frame parser.
module imu_fp_collect (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [7:0]              rx_byte,
  input  logic [7:0]              header_byte,
  output logic                    at_check,
  output imu_fp_pkg::frame_t      frame
);
  import imu_fp_pkg::*;

  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [7:0]           sum_r, sum_nxt;
  logic [FRAME_STORE_DEPTH-1:0][7:0] store_r;
  logic                 hunting;
  logic                 store_we;

  assign hunting  = (pos_r == POS_HUNT) || (pos_r > POS_CHECK);
  assign at_check = (pos_r == POS_CHECK);

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    store_we = 1'b0;
    if (accept) begin
      if (hunting) begin
        pos_nxt = POS_HUNT;
        if (rx_byte == header_byte) begin
          pos_nxt  = POS_FIRST;
          sum_nxt  = rx_byte;
          store_we = 1'b1;
        end
      end else if (pos_r < POS_CHECK) begin
        pos_nxt  = pos_r + POS_FIRST;
        sum_nxt  = sum_r + rx_byte;
        store_we = 1'b1;
      end else begin
        pos_nxt = POS_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
      sum_r <= 8'd0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // While hunting the header lands in entry zero, as the index is then forced to POS_HUNT.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[hunting ? POS_HUNT : pos_r] <= rx_byte;
    end
  end

  always_comb begin
    frame.done      = accept && at_check;
    frame.check_ok  = (store_r[0] == header_byte) && (sum_r == rx_byte);
    frame.type_byte = store_r[1];
    for (int i = 0; i < LANES; i++) begin
      frame.words[i] = {store_r[3 + 2 * i], store_r[2 + 2 * i]};
    end
  end

endmodule

// ----- src/imu_fp_decode.sv -----
// Type decode and Q16.16 scaling of a completed frame.
module imu_fp_decode (
  input  imu_fp_pkg::cfg_t                       cfg,
  input  imu_fp_pkg::frame_t                     frame,
  output logic [2:0]                             kind,
  output logic [imu_fp_pkg::LANES-1:0][31:0]     values
);
  import imu_fp_pkg::*;

  logic signed [VALUE_WIDTH-1:0] factor;
  logic signed [VALUE_WIDTH-1:0] prod [LANES];
  logic signed [15:0]            word [LANES];

  always_comb begin
    kind = KIND_BAD;
    if (frame.check_ok) begin
      // First match wins where type codes are equal.
      if (frame.type_byte == cfg.accel_type_code)      kind = KIND_ACCEL;
      else if (frame.type_byte == cfg.rate_type_code)  kind = KIND_RATE;
      else if (frame.type_byte == cfg.angle_type_code) kind = KIND_ANGLE;
      else if (frame.type_byte == cfg.quat_type_code)  kind = KIND_QUAT;
    end
  end

  always_comb begin
    case (kind)
      KIND_ACCEL: factor = SCALE_ACCEL;
      KIND_RATE:  factor = SCALE_RATE;
      KIND_ANGLE: factor = SCALE_ANGLE;
      KIND_QUAT:  factor = SCALE_QUAT;
      default:    factor = '0;
    endcase
  end

  // Products stay below 2^31; the arithmetic shift floors the acceleration.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      word[i] = signed'(frame.words[i]);
      prod[i] = 32'(word[i]) * factor;
      if (kind == KIND_ACCEL) begin
        values[i] = prod[i] >>> ACCEL_SHIFT;
      end else begin
        values[i] = prod[i];
      end
    end
    if (kind != KIND_QUAT) begin
      values[LANES-1] = '0;
    end
  end

endmodule

// ----- src/imu_fp_stats.sv -----
// Frame counters and the sticky update mask.
module imu_fp_stats #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               clear_updates,
  input  logic               done,
  input  logic [2:0]         kind,
  output imu_fp_pkg::stats_t stats
);
  import imu_fp_pkg::*;

  logic [COUNTER_WIDTH-1:0] bad_r, bad_nxt;
  logic [COUNTER_WIDTH-1:0] accel_r, accel_nxt;
  logic [COUNTER_WIDTH-1:0] rate_r, rate_nxt;
  logic [COUNTER_WIDTH-1:0] angle_r, angle_nxt;
  logic [COUNTER_WIDTH-1:0] quat_r, quat_nxt;
  logic [3:0]               mask_r, mask_nxt;
  logic [3:0]               mask_set;

  always_comb begin
    bad_nxt   = bad_r;
    accel_nxt = accel_r;
    rate_nxt  = rate_r;
    angle_nxt = angle_r;
    quat_nxt  = quat_r;
    mask_set  = 4'b0000;
    if (done) begin
      case (kind)
        KIND_ACCEL: begin
          accel_nxt = accel_r + 1'b1;
          mask_set  = 4'b0001;
        end
        KIND_RATE: begin
          rate_nxt = rate_r + 1'b1;
          mask_set = 4'b0010;
        end
        KIND_ANGLE: begin
          angle_nxt = angle_r + 1'b1;
          mask_set  = 4'b0100;
        end
        KIND_QUAT: begin
          quat_nxt = quat_r + 1'b1;
          mask_set = 4'b1000;
        end
        default: begin
          bad_nxt = bad_r + 1'b1;
        end
      endcase
    end
    // Clearing comes before this item's own bit is set.
    mask_nxt = mask_r;
    if (accept) begin
      mask_nxt = ((clear_updates) ? 4'b0000 : mask_r) | mask_set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_r   <= '0;
      accel_r <= '0;
      rate_r  <= '0;
      angle_r <= '0;
      quat_r  <= '0;
      mask_r  <= 4'b0000;
    end else begin
      bad_r   <= bad_nxt;
      accel_r <= accel_nxt;
      rate_r  <= rate_nxt;
      angle_r <= angle_nxt;
      quat_r  <= quat_nxt;
      mask_r  <= mask_nxt;
    end
  end

  always_comb begin
    stats.bad_total   = TOTAL_WIDTH'(bad_nxt);
    stats.accel_total = TOTAL_WIDTH'(accel_nxt);
    stats.rate_total  = TOTAL_WIDTH'(rate_nxt);
    stats.angle_total = TOTAL_WIDTH'(angle_nxt);
    stats.quat_total  = TOTAL_WIDTH'(quat_nxt);
    stats.update_mask = mask_nxt;
  end

endmodule

// ----- src/imu_frame_parser.sv -----
// Top level of the sum-checked 11-byte IMU frame parser.
//
// in_ch carries one received byte per item, with a flag that clears the
// sticky update mask before that byte is handled. out_ch carries one result
// item per completed frame: its kind (zero for a bad frame), four Q16.16
// values, the wrapping frame counters and the update mask after that frame.
// Bytes that do not complete a frame give no result.
// One byte is taken in every cycle but while a checksum byte is held off. The result
// of a frame appears in the output register in the cycle after its checksum byte is
// taken; the decode, one multiplier per word and the counter update sit between the
// frame store and that register.
// While a result waits in the output register, ordinary bytes are still
// taken; only a checksum byte is held off until the receiver takes the
// waiting result. cfg_we writes the register at cfg_index with cfg_data;
// indexes beyond the last register are ignored.
// Synchronous reset returns the parser to header hunting, clears counters,
// mask and the output valid flag and loads the default type codes.
module imu_frame_parser #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  imu_fp_in_if.sink                             in_ch,
  imu_fp_out_if.source                          out_ch,
  input  logic                                  cfg_we,
  input  logic [imu_fp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [7:0]                            cfg_data
);
  import imu_fp_pkg::*;

  cfg_t    cfg_r;
  frame_t  frame;
  stats_t  stats;
  result_t res_r;
  logic    out_valid_r;
  logic    at_check;
  logic    in_accept;
  logic [2:0] kind;
  logic [LANES-1:0][VALUE_WIDTH-1:0] values;

  assign in_ch.ready = !out_valid_r || out_ch.ready || !at_check;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_byte     <= RESET_HEADER;
      cfg_r.accel_type_code <= RESET_ACCEL;
      cfg_r.rate_type_code  <= RESET_RATE;
      cfg_r.angle_type_code <= RESET_ANGLE;
      cfg_r.quat_type_code  <= RESET_QUAT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER: cfg_r.header_byte     <= cfg_data;
        REG_ACCEL:  cfg_r.accel_type_code <= cfg_data;
        REG_RATE:   cfg_r.rate_type_code  <= cfg_data;
        REG_ANGLE:  cfg_r.angle_type_code <= cfg_data;
        REG_QUAT:   cfg_r.quat_type_code  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  imu_fp_collect u_collect (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .rx_byte     (in_ch.rx_byte),
    .header_byte (cfg_r.header_byte),
    .at_check    (at_check),
    .frame       (frame)
  );

  imu_fp_decode u_decode (
    .cfg    (cfg_r),
    .frame  (frame),
    .kind   (kind),
    .values (values)
  );

  imu_fp_stats #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_stats (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .clear_updates (in_ch.clear_updates),
    .done          (frame.done),
    .kind          (kind),
    .stats         (stats)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (frame.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.done) begin
      res_r.frame_kind <= kind;
      res_r.values     <= values;
      res_r.stats      <= stats;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.frame_kind  = res_r.frame_kind;
  assign out_ch.value_a     = signed'(res_r.values[0]);
  assign out_ch.value_b     = signed'(res_r.values[1]);
  assign out_ch.value_c     = signed'(res_r.values[2]);
  assign out_ch.value_d     = signed'(res_r.values[3]);
  assign out_ch.bad_total   = res_r.stats.bad_total;
  assign out_ch.accel_total = res_r.stats.accel_total;
  assign out_ch.rate_total  = res_r.stats.rate_total;
  assign out_ch.angle_total = res_r.stats.angle_total;
  assign out_ch.quat_total  = res_r.stats.quat_total;
  assign out_ch.update_mask = res_r.stats.update_mask;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the IMU frame parser, checking every frame result against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import imu_fp_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       clr;
  } serial_item_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [7:0]                 cfg_data;

  imu_fp_in_if  in_ch ();
  imu_fp_out_if out_ch ();

  imu_frame_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted parser state.
  cfg_t                 model_cfg;
  logic [POS_WIDTH-1:0] frame_pos;
  logic [7:0]           frame_buf [FRAME_STORE_DEPTH];
  logic [7:0]           frame_sum;
  logic [31:0]          bad_count;
  logic [31:0]          kind_count [4];
  logic [3:0]           sticky_mask;

  result_t      frame_results [$];
  serial_item_t byte_queue [$];
  string        lane_names [LANES] = '{"value_a", "value_b", "value_c", "value_d"};

  int n_queued      = 0;
  int n_accepted    = 0;
  int errors        = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  bit in_fire       = 1'b0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  function automatic logic [31:0] scale_word(input logic [2:0] kind, input logic [15:0] raw);
    longint d;
    longint p;
    d = longint'($signed(raw));
    case (kind)
      KIND_ACCEL: p = (d * longint'(SCALE_ACCEL)) >>> ACCEL_SHIFT;
      KIND_RATE:  p = d * longint'(SCALE_RATE);
      KIND_ANGLE: p = d * longint'(SCALE_ANGLE);
      default:    p = d * longint'(SCALE_QUAT);
    endcase
    return p[31:0];
  endfunction

  // Advances the predicted parser by one byte and records the result of a completed frame.
  task automatic parse_byte(input logic [7:0] b, input logic clr);
    result_t    res;
    logic [2:0] kind;
    if (clr) sticky_mask = 4'd0;
    if (frame_pos == POS_HUNT || frame_pos > POS_CHECK) begin
      frame_pos = POS_HUNT;
      if (b == model_cfg.header_byte) begin
        frame_buf[0] = b;
        frame_sum    = b;
        frame_pos    = POS_FIRST;
      end
    end else if (frame_pos < POS_CHECK) begin
      frame_buf[frame_pos] = b;
      frame_sum            = frame_sum + b;
      frame_pos            = frame_pos + 1'b1;
    end else begin
      frame_pos = POS_HUNT;
      kind      = KIND_BAD;
      if (frame_buf[0] == model_cfg.header_byte && frame_sum == b) begin
        if (frame_buf[1] == model_cfg.accel_type_code)      kind = KIND_ACCEL;
        else if (frame_buf[1] == model_cfg.rate_type_code)  kind = KIND_RATE;
        else if (frame_buf[1] == model_cfg.angle_type_code) kind = KIND_ANGLE;
        else if (frame_buf[1] == model_cfg.quat_type_code)  kind = KIND_QUAT;
      end
      res = '0;
      if (kind == KIND_BAD) begin
        bad_count = bad_count + 1;
      end else begin
        for (int i = 0; i < 3; i++)
          res.values[i] = scale_word(kind, {frame_buf[3 + 2 * i], frame_buf[2 + 2 * i]});
        if (kind == KIND_QUAT) res.values[3] = scale_word(kind, {frame_buf[9], frame_buf[8]});
        kind_count[kind - 1] = kind_count[kind - 1] + 1;
        sticky_mask          = sticky_mask | (4'd1 << (kind - 1));
      end
      res.frame_kind        = kind;
      res.stats.bad_total   = bad_count;
      res.stats.accel_total = kind_count[0];
      res.stats.rate_total  = kind_count[1];
      res.stats.angle_total = kind_count[2];
      res.stats.quat_total  = kind_count[3];
      res.stats.update_mask = sticky_mask;
      frame_results.push_back(res);
    end
  endtask

  function automatic logic [10:0][7:0] build_frame(input logic [7:0] hdr, input logic [7:0] typ,
                                                   input logic [3:0][15:0] words,
                                                   input logic [7:0] skew);
    logic [10:0][7:0] f;
    logic [7:0]       sum;
    f[0] = hdr;
    f[1] = typ;
    for (int i = 0; i < 4; i++) begin
      f[2 + 2 * i] = words[i][7:0];
      f[3 + 2 * i] = words[i][15:8];
    end
    sum = 8'd0;
    for (int i = 0; i < 10; i++) sum = sum + f[i];
    f[10] = sum + skew;
    return f;
  endfunction

  function automatic logic [3:0][15:0] random_words();
    logic [3:0][15:0] w;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 7))
        0:       w[i] = 16'h7FFF;
        1:       w[i] = 16'h8000;
        2:       w[i] = 16'h0000;
        3:       w[i] = 16'hFFFF;
        default: w[i] = 16'($urandom_range(0, 16'hFFFF));
      endcase
    end
    return w;
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 3))
      0:       return model_cfg.accel_type_code;
      1:       return model_cfg.rate_type_code;
      2:       return model_cfg.angle_type_code;
      default: return model_cfg.quat_type_code;
    endcase
  endfunction

  task automatic queue_byte(input logic [7:0] data, input logic clr);
    byte_queue.push_back('{data: data, clr: clr});
    n_queued++;
  endtask

  task automatic queue_frame_bytes(input logic [10:0][7:0] f, input int first, input int last,
                                   input bit clr_last);
    for (int i = first; i <= last; i++)
      queue_byte(f[i], (i == last && clr_last) || $urandom_range(0, 7) == 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Returns once every queued item has been taken and every frame result has come back.
  task automatic wait_drained();
    while (n_accepted != n_queued || frame_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed frames with random content, plus corrupt, truncated and stray bytes.
  task automatic run_random_phase(input int goal);
    int               sent;
    int               r;
    int               k;
    logic [10:0][7:0] f;
    sent = 0;
    while (sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        f = build_frame(model_cfg.header_byte, pick_code(), random_words(), 8'd0);
        queue_frame_bytes(f, 0, 10, 1'b0);
        sent += 11;
      end else if (r < 88) begin
        f = build_frame(model_cfg.header_byte, pick_code(), random_words(),
                        8'($urandom_range(1, 255)));
        queue_frame_bytes(f, 0, 10, 1'b0);
        sent += 11;
      end else if (r < 93) begin
        f = build_frame(model_cfg.header_byte, 8'($urandom_range(0, 255)), random_words(), 8'd0);
        queue_frame_bytes(f, 0, 10, 1'b0);
        sent += 11;
      end else if (r < 97) begin
        k = $urandom_range(1, 9);
        f = build_frame(model_cfg.header_byte, pick_code(), random_words(), 8'd0);
        queue_frame_bytes(f, 0, k, 1'b0);
        sent += k + 1;
      end else begin
        k = $urandom_range(1, 3);
        repeat (k)
          queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent += k;
      end
    end
  endtask

  // Byte driver: a new item is put up only once the previous one has been taken.
  always @(negedge clk) begin
    serial_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = byte_queue.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.rx_byte       <= nxt.data;
        in_ch.clear_updates <= nxt.clr;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with random stalls and the occasional long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: checks results first, then applies register writes and accepted bytes.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      model_cfg   = '{RESET_HEADER, RESET_ACCEL, RESET_RATE, RESET_ANGLE, RESET_QUAT};
      frame_pos   = POS_HUNT;
      frame_sum   = 8'd0;
      bad_count   = '0;
      sticky_mask = 4'd0;
      for (int i = 0; i < FRAME_STORE_DEPTH; i++) frame_buf[i] = 8'd0;
      for (int i = 0; i < 4; i++) kind_count[i] = '0;
      in_fire = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.frame_kind = out_ch.frame_kind;
        got.values     = {out_ch.value_d, out_ch.value_c, out_ch.value_b, out_ch.value_a};
        got.stats      = '{out_ch.bad_total, out_ch.accel_total, out_ch.rate_total,
                           out_ch.angle_total, out_ch.quat_total, out_ch.update_mask};
        if (frame_results.size() == 0) begin
          report_mismatch($sformatf("result of kind %0d with none expected", got.frame_kind));
        end else begin
          want = frame_results.pop_front();
          if (got.frame_kind !== want.frame_kind)
            report_mismatch($sformatf("frame_kind %0d, expected %0d",
                                      got.frame_kind, want.frame_kind));
          for (int i = 0; i < LANES; i++)
            if (got.values[i] !== want.values[i])
              report_mismatch($sformatf("%s %h, expected %h", lane_names[i],
                                        got.values[i], want.values[i]));
          if (got.stats.bad_total !== want.stats.bad_total)
            report_mismatch($sformatf("bad_total %0d, expected %0d",
                                      got.stats.bad_total, want.stats.bad_total));
          if (got.stats.accel_total !== want.stats.accel_total)
            report_mismatch($sformatf("accel_total %0d, expected %0d",
                                      got.stats.accel_total, want.stats.accel_total));
          if (got.stats.rate_total !== want.stats.rate_total)
            report_mismatch($sformatf("rate_total %0d, expected %0d",
                                      got.stats.rate_total, want.stats.rate_total));
          if (got.stats.angle_total !== want.stats.angle_total)
            report_mismatch($sformatf("angle_total %0d, expected %0d",
                                      got.stats.angle_total, want.stats.angle_total));
          if (got.stats.quat_total !== want.stats.quat_total)
            report_mismatch($sformatf("quat_total %0d, expected %0d",
                                      got.stats.quat_total, want.stats.quat_total));
          if (got.stats.update_mask !== want.stats.update_mask)
            report_mismatch($sformatf("update_mask %b, expected %b",
                                      got.stats.update_mask, want.stats.update_mask));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_HEADER: model_cfg.header_byte     = cfg_data;
          REG_ACCEL:  model_cfg.accel_type_code = cfg_data;
          REG_RATE:   model_cfg.rate_type_code  = cfg_data;
          REG_ANGLE:  model_cfg.angle_type_code = cfg_data;
          REG_QUAT:   model_cfg.quat_type_code  = cfg_data;
          default: ;
        endcase
      end
      in_fire = in_ch.valid && in_ch.ready;
      if (in_fire) begin
        parse_byte(in_ch.rx_byte, in_ch.clear_updates);
        n_accepted++;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Timed out after %0d cycles without a transfer", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [10:0][7:0] f;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_HEADER;
    cfg_data            = 8'd0;
    in_ch.valid         = 1'b0;
    in_ch.rx_byte       = 8'd0;
    in_ch.clear_updates = 1'b0;
    out_ch.ready        = 1'b0;
    send_idle_pct       = 36;
    recv_idle_pct       = 59;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Stray bytes while hunting, every kind with extreme words, a bad checksum and an unknown type.
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_frame_bytes(build_frame(RESET_HEADER, RESET_ACCEL,
                                  {16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF}, 8'd0), 0, 10, 1'b0);
    queue_frame_bytes(build_frame(RESET_HEADER, RESET_RATE,
                                  {16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000}, 8'd0), 0, 10, 1'b0);
    queue_frame_bytes(build_frame(RESET_HEADER, RESET_ANGLE,
                                  {16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF}, 8'd0), 0, 10, 1'b0);
    // The clear arrives with the checksum byte, so only the quaternion bit survives.
    queue_frame_bytes(build_frame(RESET_HEADER, RESET_QUAT,
                                  {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001}, 8'd0), 0, 10, 1'b1);
    queue_frame_bytes(build_frame(RESET_HEADER, RESET_ACCEL, random_words(), 8'd1),
                      0, 10, 1'b0);
    queue_frame_bytes(build_frame(RESET_HEADER, 8'h00, random_words(), 8'd0), 0, 10, 1'b0);
    wait_drained();

    // The header register changes while a frame is half collected, so the frame is bad.
    f = build_frame(RESET_HEADER, RESET_RATE, random_words(), 8'd0);
    queue_frame_bytes(f, 0, 4, 1'b0);
    wait_drained();
    write_reg(REG_HEADER, 8'h3C);
    queue_frame_bytes(f, 5, 10, 1'b0);
    wait_drained();

    // Shared type codes resolve to acceleration; writes past the last register do nothing.
    write_reg(REG_HEADER, RESET_HEADER);
    write_reg(REG_RATE, RESET_ACCEL);
    write_reg(REG_QUAT + 3'd1, 8'h00);
    write_reg(REG_SPARE, 8'h00);
    queue_frame_bytes(build_frame(RESET_HEADER, RESET_ACCEL, random_words(), 8'd0),
                      0, 10, 1'b0);
    queue_frame_bytes(build_frame(RESET_HEADER, RESET_RATE, random_words(), 8'd0),
                      0, 10, 1'b0);
    wait_drained();

    write_reg(REG_HEADER, 8'hFF);
    write_reg(REG_ACCEL, 8'h00);
    write_reg(REG_RATE, 8'hFF);
    write_reg(REG_ANGLE, 8'h01);
    write_reg(REG_QUAT, 8'h80);
    run_random_phase(100);
    wait_drained();

    send_idle_pct = 59;
    recv_idle_pct = 36;
    write_reg(REG_HEADER, 8'h00);
    write_reg(REG_ACCEL, 8'($urandom_range(0, 255)));
    write_reg(REG_RATE, 8'($urandom_range(0, 255)));
    write_reg(REG_ANGLE, 8'($urandom_range(0, 255)));
    write_reg(REG_QUAT, 8'($urandom_range(0, 255)));
    run_random_phase(100);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_HEADER, RESET_HEADER);
    write_reg(REG_ACCEL, RESET_ACCEL);
    write_reg(REG_RATE, RESET_RATE);
    write_reg(REG_ANGLE, RESET_ANGLE);
    write_reg(REG_QUAT, RESET_QUAT);
    // Long receiver hold-off while frames keep coming, so the parser backs up.
    hold_req++;
    repeat (8)
      queue_frame_bytes(build_frame(RESET_HEADER, pick_code(), random_words(), 8'd0),
                        0, 10, 1'b0);
    wait_drained();
    run_random_phase(60);
    wait_drained();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- imu_frame_parser.f -----
src/imu_fp_pkg.sv
src/imu_fp_in_if.sv
src/imu_fp_out_if.sv
src/imu_fp_collect.sv
src/imu_fp_decode.sv
src/imu_fp_stats.sv
src/imu_frame_parser.sv
bench/tb_top.sv
